FILE: rtl/core/nclru_pkg.sv
// Shared types and constants for the name cache LRU table.
`timescale 1ns / 1ps
package nclru_pkg;

  localparam int ENTRIES    = 64;
  localparam int NAME_BYTES = 8;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int IN_W       = 200;
  localparam int OUT_W      = 336;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_INVAL  = 3'd3,
    OP_EVICT  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_FAIL    = 2'd0,
    ST_DONE    = 2'd1,
    ST_NEG_HIT = 2'd2,
    ST_POS_HIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RESULT
  } state_t;

  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_NEG_OK = 1'b1
  } cfg_idx_t;

  // stamp orders entries by last use: smallest stamp is least recent
  typedef struct packed {
    logic [63:0] parent;
    logic [63:0] name;
    logic [3:0]  len;
    logic [63:0] inode;
    logic [63:0] stamp;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] parent;
    logic [63:0] name;
    logic [3:0]  len;
    logic [63:0] inode;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found;
    logic [6:0]  removed;
    logic [6:0]  entries;
    logic [63:0] hits;
    logic [63:0] misses;
    logic [63:0] neg_hits;
    logic [63:0] evictions;
  } result_t;

endpackage

FILE: rtl/core/nclru_store.sv
// Slot record memory with one read port, one write port and registered read data.
`timescale 1ns / 1ps
module nclru_store (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [nclru_pkg::IDX_W-1:0]         rd_addr,
  output nclru_pkg::slot_rec_t                rd_data_r,
  input  logic                                wr_en,
  input  logic [nclru_pkg::IDX_W-1:0]         wr_addr,
  input  nclru_pkg::slot_rec_t                wr_data
);
  import nclru_pkg::*;

  slot_rec_t mem_r [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

FILE: rtl/core/nclru_ctrl.sv
// Sequencer: scans the slot store, tracks valid bits, counters and LRU.
`timescale 1ns / 1ps
module nclru_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  nclru_pkg::request_t          req,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [0:0]                   cfg_data,
  output logic                         mem_rd_en,
  output logic [nclru_pkg::IDX_W-1:0]  mem_rd_addr,
  input  nclru_pkg::slot_rec_t         mem_rd_data,
  output logic                         mem_wr_en,
  output logic [nclru_pkg::IDX_W-1:0]  mem_wr_addr,
  output nclru_pkg::slot_rec_t         mem_wr_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output nclru_pkg::result_t           res_r
);
  import nclru_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  state_t state_r, state_nxt;

  logic             enable_r, neg_ok_r;
  request_t         req_r;
  logic             len_ok_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0] count_r;
  logic [63:0]      hits_r, misses_r, negs_r, evicts_r, stamp_r;

  logic [CNT_W-1:0] issue_cnt_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic             hit_r, free_r, min_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, min_idx_r;
  slot_rec_t        hit_rec_r;
  logic [63:0]      min_stamp_r;
  logic [CNT_W-1:0] removed_r;

  // incoming request decode
  logic [63:0] in_name;
  logic        in_len_ok, in_scan, accept;

  always_comb begin
    in_len_ok = (req.len != 4'd0) && (req.len <= 4'(NAME_BYTES));
    for (int b = 0; b < 8; b++) begin
      in_name[b*8 +: 8] = (in_len_ok && b < NAME_BYTES && 4'(b) < req.len) ?
                          req.name[b*8 +: 8] : 8'd0;
    end
    unique case (req.op)
      OP_LOOKUP: in_scan = in_len_ok && enable_r;
      OP_INSERT: in_scan = in_len_ok && enable_r && !((req.inode == 64'd0) && !neg_ok_r);
      OP_REMOVE: in_scan = in_len_ok;
      OP_INVAL:  in_scan = 1'b1;
      OP_EVICT:  in_scan = (count_r != '0);
      default:   in_scan = 1'b0;
    endcase
  end

  assign accept = req_valid && req_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (req_valid) state_nxt = in_scan ? S_SCAN : S_FIN;
      S_SCAN:   if (rd_vld_r && rd_idx_r == IDX_LAST) state_nxt = S_FIN;
      S_FIN:    state_nxt = S_RESULT;
      S_RESULT: if (res_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = (state_r == S_IDLE);
    mem_rd_en   = (state_r == S_SCAN) && (issue_cnt_r < CNT_FULL);
    mem_rd_addr = issue_cnt_r[IDX_W-1:0];
    res_valid   = (state_r == S_RESULT);
  end

  // scan compare on the slot that came back from the store
  logic rd_live, rd_key_hit, rd_parent_hit;
  assign rd_live       = (state_r == S_SCAN) && rd_vld_r;
  assign rd_parent_hit = valid_r[rd_idx_r] && (mem_rd_data.parent == req_r.parent);
  assign rd_key_hit    = rd_parent_hit && (mem_rd_data.len == req_r.len) &&
                         (mem_rd_data.name == req_r.name);

  // finish step
  logic             fin_wr;
  logic [IDX_W-1:0] fin_addr;
  slot_rec_t        fin_rec;
  logic             fin_vset, fin_vclr, fin_all_clr;
  logic [IDX_W-1:0] fin_vidx;
  logic [CNT_W-1:0] fin_count;
  logic [63:0]      fin_hits, fin_misses, fin_negs, fin_evicts;
  logic [1:0]       fin_status;
  logic [63:0]      fin_found;
  logic             ins_ok;

  always_comb begin
    fin_wr      = 1'b0;
    fin_addr    = hit_idx_r;
    fin_rec     = hit_rec_r;
    fin_rec.stamp = stamp_r;
    fin_vset    = 1'b0;
    fin_vclr    = 1'b0;
    fin_all_clr = 1'b0;
    fin_vidx    = hit_idx_r;
    fin_count   = count_r;
    fin_hits    = hits_r;
    fin_misses  = misses_r;
    fin_negs    = negs_r;
    fin_evicts  = evicts_r;
    fin_status  = ST_FAIL;
    fin_found   = 64'd0;
    ins_ok      = len_ok_r && enable_r && !((req_r.inode == 64'd0) && !neg_ok_r);
    unique case (req_r.op)
      OP_LOOKUP: begin
        if (hit_r) begin
          fin_wr   = 1'b1;
          fin_hits = hits_r + 64'd1;
          if (hit_rec_r.inode == 64'd0) begin
            fin_negs   = negs_r + 64'd1;
            fin_status = ST_NEG_HIT;
          end else begin
            fin_found  = hit_rec_r.inode;
            fin_status = ST_POS_HIT;
          end
        end else begin
          fin_misses = misses_r + 64'd1;
        end
      end
      OP_INSERT: begin
        if (ins_ok) begin
          fin_wr     = 1'b1;
          fin_status = ST_DONE;
          if (hit_r) begin
            fin_rec.inode = req_r.inode;
          end else begin
            fin_rec = '{parent: req_r.parent, name: req_r.name, len: req_r.len,
                        inode: req_r.inode, stamp: stamp_r};
            fin_vset = 1'b1;
            if (count_r == CNT_FULL) begin
              // replace the least recent slot
              fin_addr   = min_idx_r;
              fin_evicts = evicts_r + 64'd1;
            end else begin
              fin_addr  = free_idx_r;
              fin_count = count_r + 1'b1;
            end
            fin_vidx = fin_addr;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_r) begin
          fin_vclr   = 1'b1;
          fin_count  = count_r - 1'b1;
          fin_status = ST_DONE;
        end
      end
      OP_INVAL: fin_status = ST_DONE;
      OP_EVICT: begin
        if (min_r) begin
          fin_vclr   = 1'b1;
          fin_vidx   = min_idx_r;
          fin_count  = count_r - 1'b1;
          fin_evicts = evicts_r + 64'd1;
          fin_status = ST_DONE;
        end
      end
      OP_CLEAR: begin
        fin_all_clr = 1'b1;
        fin_count   = '0;
        fin_status  = ST_DONE;
      end
      default: fin_status = ST_FAIL;
    endcase
  end

  assign mem_wr_en   = (state_r == S_FIN) && fin_wr;
  assign mem_wr_addr = fin_addr;
  assign mem_wr_data = fin_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      neg_ok_r    <= 1'b1;
      valid_r     <= '0;
      count_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      negs_r      <= '0;
      evicts_r    <= '0;
      stamp_r     <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      min_r       <= 1'b0;
      removed_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE: enable_r <= cfg_data[0];
          CFG_NEG_OK: neg_ok_r <= cfg_data[0];
          default:    enable_r <= enable_r;
        endcase
      end
      if (accept) begin
        issue_cnt_r <= '0;
        rd_vld_r    <= 1'b0;
        hit_r       <= 1'b0;
        free_r      <= 1'b0;
        min_r       <= 1'b0;
        removed_r   <= '0;
      end
      if (state_r == S_SCAN) begin
        rd_vld_r <= mem_rd_en;
        if (mem_rd_en) issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (rd_live) begin
        if (rd_key_hit && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
          hit_rec_r <= mem_rd_data;
        end
        if (!valid_r[rd_idx_r] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
        if (valid_r[rd_idx_r] && (!min_r || mem_rd_data.stamp < min_stamp_r)) begin
          min_r       <= 1'b1;
          min_idx_r   <= rd_idx_r;
          min_stamp_r <= mem_rd_data.stamp;
        end
        // drop every entry of the parent as it streams by
        if (req_r.op == OP_INVAL && rd_parent_hit) begin
          valid_r[rd_idx_r] <= 1'b0;
          count_r           <= count_r - 1'b1;
          removed_r         <= removed_r + 1'b1;
        end
      end
      if (state_r == S_FIN) begin
        count_r  <= fin_count;
        hits_r   <= fin_hits;
        misses_r <= fin_misses;
        negs_r   <= fin_negs;
        evicts_r <= fin_evicts;
        if (fin_wr) stamp_r <= stamp_r + 64'd1;
        if (fin_all_clr) begin
          valid_r <= '0;
        end else if (fin_vset) begin
          valid_r[fin_vidx] <= 1'b1;
        end else if (fin_vclr) begin
          valid_r[fin_vidx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req;
      req_r.name <= in_name;
      len_ok_r   <= in_len_ok;
    end
    if (state_r == S_SCAN) begin
      rd_idx_r <= issue_cnt_r[IDX_W-1:0];
    end
    if (state_r == S_FIN) begin
      res_r.status    <= fin_status;
      res_r.found     <= fin_found;
      res_r.removed   <= (req_r.op == OP_INVAL) ? 7'(removed_r) : 7'd0;
      res_r.entries   <= 7'(fin_count);
      res_r.hits      <= fin_hits;
      res_r.misses    <= fin_misses;
      res_r.neg_hits  <= fin_negs;
      res_r.evictions <= fin_evicts;
    end
  end

endmodule

FILE: rtl/core/name_cache_lru_table.sv
// Top level of the name cache LRU table: store, sequencer and result register.
//
//   channel  | dir | handshake                | payload
//   in_      | in  | in_tvalid / in_tready    | in_tdata (200 bits)
//   out_     | out | out_tvalid / out_tready  | out_tdata (336 bits)
//   cfg_     | in  | cfg_we                   | cfg_index, cfg_data
//
// Lookup, insert, remove, invalidate and evict read every slot of the
// slot store one per cycle through its one read port.
// Clear and requests rejected up front skip the scan.
// Reset clears all valid marks and counters at once; no clearing pass.
// A finished result sits in the output register while the next request
// is taken; the sequencer holds only when that register is still full.
`timescale 1ns / 1ps
module name_cache_lru_table (
  input  logic                        clk,
  input  logic                        rst_n,
  // operation, parent_inode, name_bytes, name_length, new_inode, pad
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [nclru_pkg::IN_W-1:0]  in_tdata,
  // status, found_inode, removed_count, entry_count, hit_total,
  // miss_total, negative_hit_total, eviction_total
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nclru_pkg::OUT_W-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [0:0]                  cfg_data
);
  import nclru_pkg::*;

  request_t         req;
  slot_rec_t        rd_data, wr_data;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             res_valid, res_ready;
  result_t          res;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign req.op     = in_tdata[2:0];
  assign req.parent = in_tdata[66:3];
  assign req.name   = in_tdata[130:67];
  assign req.len    = in_tdata[134:131];
  assign req.inode  = in_tdata[198:135];

  nclru_store u_store (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  nclru_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_r       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {res.evictions, res.neg_hits, res.misses, res.hits,
                     res.entries, res.removed, res.found, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the name cache LRU table: a prediction scoreboard and stream drivers.
`timescale 1ns / 1ps
module testbench;
  import nclru_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int SLOTS = 64;
  localparam int KEY_POOL = 96;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] parent;
    logic [63:0] name;
    logic [3:0]  len;
    logic [63:0] inode;
  } cache_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] found;
    logic [6:0]  removed;
    logic [6:0]  entries;
    logic [63:0] hits;
    logic [63:0] misses;
    logic [63:0] neg_hits;
    logic [63:0] evictions;
  } cache_reply_t;

  class lru_cache_scoreboard;
    bit          enabled, neg_ok;
    bit          live[SLOTS];
    logic [63:0] s_parent[SLOTS], s_name[SLOTS], s_inode[SLOTS];
    logic [3:0]  s_len[SLOTS];
    bit          s_neg[SLOTS];
    int          s_rank[SLOTS];
    int          live_count;
    logic [63:0] hits, misses, neg_hits, evictions;
    cache_reply_t awaited[$];
    int          errors;

    function new();
      enabled = 1; neg_ok = 1; live_count = 0;
      hits = 0; misses = 0; neg_hits = 0; evictions = 0; errors = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function int find_key(logic [63:0] p, logic [63:0] n, logic [3:0] l);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && s_parent[i] == p && s_len[i] == l && s_name[i] == n) return i;
      return -1;
    endfunction

    function void make_recent(int s);
      int r;
      r = s_rank[s];
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && s_rank[i] < r) s_rank[i]++;
      s_rank[s] = 0;
    endfunction

    function void drop(int s);
      int r;
      r = s_rank[s];
      live[s] = 0;
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && s_rank[i] > r) s_rank[i]--;
      if (live_count > 0) live_count--;
    endfunction

    function bit evict_oldest();
      if (live_count == 0) return 0;
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && s_rank[i] == live_count - 1) begin
          drop(i);
          evictions++;
          return 1;
        end
      return 0;
    endfunction

    function void note_request(cache_req_t r);
      cache_reply_t e;
      bit len_ok;
      logic [63:0] key_name, mask;
      int s;
      e.status = ST_FAIL; e.found = '0; e.removed = '0;
      len_ok = (r.len != 0) && (r.len <= NAME_BYTES);
      mask = (r.len >= 8) ? '1 : ((64'd1 << (8 * r.len)) - 64'd1);
      key_name = len_ok ? (r.name & mask) : 64'd0;
      case (r.op)
        OP_LOOKUP: begin
          s = (len_ok && enabled) ? find_key(r.parent, key_name, r.len) : -1;
          if (s < 0) misses++;
          else begin
            make_recent(s);
            hits++;
            if (s_neg[s]) begin
              neg_hits++;
              e.status = ST_NEG_HIT;
            end else begin
              e.found = s_inode[s];
              e.status = ST_POS_HIT;
            end
          end
        end
        OP_INSERT: begin
          if (len_ok && enabled && !(r.inode == 0 && !neg_ok)) begin
            s = find_key(r.parent, key_name, r.len);
            if (s >= 0) begin
              s_inode[s] = r.inode;
              s_neg[s] = (r.inode == 0);
              make_recent(s);
              e.status = ST_DONE;
            end else begin
              if (live_count >= SLOTS) void'(evict_oldest());
              for (int i = 0; i < SLOTS; i++)
                if (!live[i]) begin
                  s = i;
                  break;
                end
              if (s >= 0) begin
                for (int i = 0; i < SLOTS; i++)
                  if (live[i]) s_rank[i]++;
                live[s] = 1; s_parent[s] = r.parent; s_name[s] = key_name;
                s_len[s] = r.len; s_inode[s] = r.inode; s_neg[s] = (r.inode == 0);
                s_rank[s] = 0;
                live_count++;
                e.status = ST_DONE;
              end
            end
          end
        end
        OP_REMOVE: begin
          s = len_ok ? find_key(r.parent, key_name, r.len) : -1;
          if (s >= 0) begin
            drop(s);
            e.status = ST_DONE;
          end
        end
        OP_INVAL: begin
          for (int i = 0; i < SLOTS; i++)
            if (live[i] && s_parent[i] == r.parent) begin
              drop(i);
              e.removed++;
            end
          e.status = ST_DONE;
        end
        OP_EVICT: e.status = evict_oldest() ? ST_DONE : ST_FAIL;
        OP_CLEAR: begin
          foreach (live[i]) live[i] = 0;
          live_count = 0;
          e.status = ST_DONE;
        end
        default: ;
      endcase
      e.entries = 7'(live_count);
      e.hits = hits; e.misses = misses; e.neg_hits = neg_hits; e.evictions = evictions;
      awaited.push_back(e);
    endfunction

    function void check_reply(cache_reply_t a);
      cache_reply_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected reply: status %0d", a.status);
        return;
      end
      e = awaited.pop_front();
      if (a.status !== e.status || a.found !== e.found || a.removed !== e.removed ||
          a.entries !== e.entries || a.hits !== e.hits || a.misses !== e.misses ||
          a.neg_hits !== e.neg_hits || a.evictions !== e.evictions) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: st %0d ino %h rm %0d n %0d h %0d m %0d nh %0d ev %0d",
                   e.status, e.found, e.removed, e.entries, e.hits, e.misses,
                   e.neg_hits, e.evictions);
          $display("         got: st %0d ino %h rm %0d n %0d h %0d m %0d nh %0d ev %0d",
                   a.status, a.found, a.removed, a.entries, a.hits, a.misses,
                   a.neg_hits, a.evictions);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [0:0] cfg_data = '0;

  lru_cache_scoreboard sb = new();
  int tx_idle_pct = 0, rx_stall_pct = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int cycles = 0;
  logic [63:0] pool_parent[KEY_POOL], pool_name[KEY_POOL];
  logic [3:0]  pool_len[KEY_POOL];
  logic [63:0] parents[8];

  name_cache_lru_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cache_req_t r;
    cache_reply_t a;
    if (rst_n && in_tvalid && in_tready) begin
      r.op = in_tdata[2:0]; r.parent = in_tdata[66:3]; r.name = in_tdata[130:67];
      r.len = in_tdata[134:131]; r.inode = in_tdata[198:135];
      sb.note_request(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      a.status = out_tdata[1:0]; a.found = out_tdata[65:2]; a.removed = out_tdata[72:66];
      a.entries = out_tdata[79:73]; a.hits = out_tdata[143:80];
      a.misses = out_tdata[207:144]; a.neg_hits = out_tdata[271:208];
      a.evictions = out_tdata[335:272];
      sb.check_reply(a);
    end
  end

  task automatic send(logic [2:0] op, logic [63:0] parent, logic [63:0] name,
                      logic [3:0] len, logic [63:0] inode);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, inode, len, name, parent, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    // let the monitor record the last accepted request first
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(bit en, bit neg);
    cfg_we <= 1; cfg_index <= CFG_ENABLE; cfg_data <= en;
    @(posedge clk);
    cfg_index <= CFG_NEG_OK; cfg_data <= neg;
    @(posedge clk);
    cfg_we <= 0;
    sb.enabled = en;
    sb.neg_ok = neg;
  endtask

  // well-formed key from the pool, with junk above the name length
  task automatic send_pool(logic [2:0] op);
    int k;
    logic [63:0] mask;
    logic [63:0] ino;
    k = $urandom_range(KEY_POOL - 1);
    mask = (pool_len[k] >= 8) ? '1 : ((64'd1 << (8 * pool_len[k])) - 64'd1);
    ino = ($urandom_range(99) < 15) ? 64'd0 : {$urandom, $urandom};
    send(op, pool_parent[k], (pool_name[k] & mask) | ({$urandom, $urandom} & ~mask),
         pool_len[k], ino);
  endtask

  task automatic send_random();
    int pick;
    logic [3:0] bad_len;
    pick = $urandom_range(999);
    if (pick < 360) send_pool(OP_LOOKUP);
    else if (pick < 720) send_pool(OP_INSERT);
    else if (pick < 820) send_pool(OP_REMOVE);
    else if (pick < 880) send(OP_INVAL, parents[$urandom_range(7)], 0, 0, 0);
    else if (pick < 925) send(OP_EVICT, {$urandom, $urandom}, 0, 0, 0);
    else if (pick < 930) send(OP_CLEAR, 0, 0, 0, 0);
    else if (pick < 980) begin
      bad_len = ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
      send(3'($urandom_range(OP_LOOKUP, OP_REMOVE)), parents[$urandom_range(7)],
           {$urandom, $urandom}, bad_len, {$urandom, $urandom});
    end else
      send(($urandom_range(1) != 0) ? OP_SPARE6 : OP_SPARE7, {$urandom, $urandom},
           {$urandom, $urandom}, 4'($urandom), {$urandom, $urandom});
  endtask

  initial begin
    bit seg_en[6]  = '{1, 1, 0, 1, 1, 1};
    bit seg_neg[6] = '{1, 0, 1, 1, 0, 1};
    parents[0] = 0;
    parents[1] = '1;
    for (int i = 2; i < 8; i++) parents[i] = {$urandom, $urandom};
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_parent[i] = parents[$urandom_range(7)];
      pool_name[i] = {$urandom, $urandom};
      pool_len[i] = 4'($urandom_range(1, NAME_BYTES));
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, each operation, special cases
    send(OP_LOOKUP, 0, 0, 1, 0);
    send(OP_EVICT, 0, 0, 0, 0);
    send(OP_INSERT, 0, 64'hFFFF_FFFF_FFFF_FF00, 1, 64'h1);
    send(OP_INSERT, '1, '1, 8, '1);
    send(OP_LOOKUP, '1, '1, 8, 0);
    send(OP_LOOKUP, 0, 64'h1234_5678_9ABC_DE00, 1, 0);
    send(OP_INSERT, 64'h55, 64'h6f6f66, 3, 0);
    send(OP_LOOKUP, 64'h55, 64'hAA00_0000_006f_6f66, 3, 0);
    send(OP_INSERT, 64'h55, 64'h6f6f66, 3, 64'h77);
    send(OP_LOOKUP, 64'h55, 64'h6f6f66, 3, 0);
    send(OP_LOOKUP, 64'h55, 64'h6f6f66, 0, 0);
    send(OP_INSERT, 64'h55, 64'h6f6f66, 9, 64'h5);
    send(OP_REMOVE, 64'h55, 64'h6f6f66, 15, 0);
    send(OP_REMOVE, 64'h56, 64'h6f6f66, 3, 0);
    send(OP_REMOVE, 64'h55, 64'h6f6f66, 3, 0);
    send(OP_INSERT, '1, 64'h41, 1, 64'h8000_0000_0000_0000);
    send(OP_INVAL, '1, 0, 0, 0);
    send(OP_INVAL, 64'h999, 0, 0, 0);
    send(OP_EVICT, 0, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0);
    send(OP_EVICT, 0, 0, 0, 0);
    send(OP_SPARE6, '1, '1, '1, '1);
    send(OP_SPARE7, 0, 0, 0, 0);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin tx_idle_pct = 13; rx_stall_pct = 84; end
        1: begin tx_idle_pct = 84; rx_stall_pct = 13; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      set_mode(seg_en[seg], seg_neg[seg]);
      for (int n = 0; n < 117; n++) begin
        // hold the receiver off while requests keep coming
        if ((seg == 1 || seg == 4) && n == 40) hold_reqs = hold_reqs + 1;
        send_random();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
